// File: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, constants and helpers of the IPv4 longest prefix router.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 6;
    localparam int PORT_W      = 4;
    localparam int VER_W       = 4;
    localparam int TTL_W       = 8;
    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [LEN_W-1:0]  MAX_LEN      = 6'd32;
    localparam logic [VER_W-1:0]  IPV4_VERSION = 4'd4;
    localparam logic [TTL_W-1:0]  TTL_MIN      = 8'd2;
    localparam logic [ADDR_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_ROUTE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        V_FORWARD = 3'd0,
        V_BADVER  = 3'd1,
        V_TTL     = 3'd2,
        V_NOROUTE = 3'd3,
        V_ADDED   = 3'd4,
        V_FULL    = 3'd5
    } t_verdict;

    // One table entry as stored in the route RAM
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] hop;
        logic              direct;
        logic [PORT_W-1:0] port;
    } t_route;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic write;
        logic scan_clear;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_add;
        logic full;
        logic pre_fail;
        logic empty;
        logic scan_last;
        logic out_free;
    } t_status;

    // Network mask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        mask_of = ~(ALL_ONES >> len);
    endfunction

endpackage

// File: design/lpr_ram.sv
// ----------------------------------------------------------------------------
// lpr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: accept, decide, scan the route table, drain, hand off result.
// ----------------------------------------------------------------------------
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.is_add) begin
                    o_cmd.write = !i_status.full;
                    n_state     = S_DONE;
                end else if (i_status.pre_fail || i_status.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted transaction did not advance to decide");

    a_scan_ends_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.scan_last) |=> (r_state == S_DRAIN))
        else $error("last table read not followed by drain");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded over a pending transaction");

endmodule

// File: design/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// Input latch, route table RAM, prefix compare with best-match tracking,
// and the result register.
// ----------------------------------------------------------------------------
module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_operation,
    input  logic [ADDR_W-1:0] i_route_prefix_addr,
    input  logic [LEN_W-1:0]  i_route_length,
    input  logic [ADDR_W-1:0] i_route_hop_addr,
    input  logic              i_route_is_direct,
    input  logic [PORT_W-1:0] i_route_port,
    input  logic [VER_W-1:0]  i_ip_version,
    input  logic [TTL_W-1:0]  i_ttl_in,
    input  logic [ADDR_W-1:0] i_dest_addr,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_verdict,
    output logic [ADDR_W-1:0] o_hop_addr_out,
    output logic [PORT_W-1:0] o_port_out,
    output logic [TTL_W-1:0]  o_ttl_out,
    output logic [LEN_W-1:0]  o_match_length
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ROUTE_W = $bits(t_route);

    // Latched transaction
    t_op               r_op;
    logic [ADDR_W-1:0] r_prefix;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_hop;
    logic              r_direct;
    logic [PORT_W-1:0] r_port;
    logic [VER_W-1:0]  r_ver;
    logic [TTL_W-1:0]  r_ttl;
    logic [ADDR_W-1:0] r_dst;
    logic              r_added;

    // Table fill and scan
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_pend;

    // Best match so far
    logic              r_found;
    logic [LEN_W-1:0]  r_blen;
    logic [ADDR_W-1:0] r_bhop;
    logic              r_bdirect;
    logic [PORT_W-1:0] r_bport;

    // Result register
    logic              r_out_valid;
    t_verdict          r_verdict;
    logic [ADDR_W-1:0] r_hop_out;
    logic [PORT_W-1:0] r_port_out;
    logic [TTL_W-1:0]  r_ttl_out;
    logic [LEN_W-1:0]  r_mlen_out;

    logic [LEN_W-1:0]   w_len_sat;
    t_route             w_wr_route;
    logic [ROUTE_W-1:0] w_rdata;
    t_route             w_rd_route;
    logic               w_hit;
    logic               w_take;
    logic [CNT_W-1:0]   w_idx_inc;
    t_verdict           w_verdict;

    assign w_len_sat = (i_route_length > MAX_LEN) ? MAX_LEN : i_route_length;

    assign w_wr_route.prefix = r_prefix & mask_of(r_len);
    assign w_wr_route.length = r_len;
    assign w_wr_route.hop    = r_direct ? '0 : r_hop;
    assign w_wr_route.direct = r_direct;
    assign w_wr_route.port   = r_port;

    lpr_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wr_route),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_route = t_route'(w_rdata);
    assign w_hit      = (r_dst & mask_of(w_rd_route.length)) == w_rd_route.prefix;
    // Later entry wins on an equal length
    assign w_take     = r_rd_pend && w_hit && (!r_found || w_rd_route.length >= r_blen);
    assign w_idx_inc  = CNT_W'(r_idx) + CNT_W'(1);

    always_comb begin
        if (r_op == OP_ADD) begin
            w_verdict = r_added ? V_ADDED : V_FULL;
        end else if (r_ver != IPV4_VERSION) begin
            w_verdict = V_BADVER;
        end else if (r_ttl < TTL_MIN) begin
            w_verdict = V_TTL;
        end else if (!r_found) begin
            w_verdict = V_NOROUTE;
        end else begin
            w_verdict = V_FORWARD;
        end
    end

    assign o_status.is_add    = (r_op == OP_ADD);
    assign o_status.full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_status.pre_fail  = (r_ver != IPV4_VERSION) || (r_ttl < TTL_MIN);
    assign o_status.empty     = (r_count == '0);
    assign o_status.scan_last = (w_idx_inc == r_count);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.write) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= t_op'(i_operation);
            r_prefix <= i_route_prefix_addr;
            r_len    <= w_len_sat;
            r_hop    <= i_route_hop_addr;
            r_direct <= i_route_is_direct;
            r_port   <= i_route_port;
            r_ver    <= i_ip_version;
            r_ttl    <= i_ttl_in;
            r_dst    <= i_dest_addr;
            r_added  <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_added <= 1'b1;
            end
            if (w_take) begin
                r_found   <= 1'b1;
                r_blen    <= w_rd_route.length;
                r_bhop    <= w_rd_route.hop;
                r_bdirect <= w_rd_route.direct;
                r_bport   <= w_rd_route.port;
            end
        end

        if (i_cmd.scan_clear) begin
            r_idx <= '0;
        end else if (i_cmd.rd_issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end

        if (i_cmd.load_out) begin
            r_verdict <= w_verdict;
            if (w_verdict == V_FORWARD) begin
                r_hop_out  <= r_bdirect ? r_dst : r_bhop;
                r_port_out <= r_bport;
                r_ttl_out  <= r_ttl - TTL_W'(1);
                r_mlen_out <= r_blen;
            end else begin
                r_hop_out  <= '0;
                r_port_out <= '0;
                r_ttl_out  <= '0;
                r_mlen_out <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_hop_addr_out = r_hop_out;
    assign o_port_out     = r_port_out;
    assign o_ttl_out      = r_ttl_out;
    assign o_match_length = r_mlen_out;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("route count beyond table depth");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (r_count != CNT_W'(TABLE_DEPTH)))
        else $error("route written into a full table");

    a_read_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (CNT_W'(r_idx) < r_count))
        else $error("scan read past the filled entries");

endmodule

// File: design/ipv4_longest_prefix_router_core.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router_core
// IPv4 route table with append-only adds and longest prefix match lookup.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ------------------------------
//   in        input      i_in_valid / o_in_ready   operation, route_*, ip_version,
//                                                  ttl_in, dest_addr
//   out       output     o_out_valid / i_out_ready verdict, hop_addr_out, port_out,
//                                                  ttl_out, match_length
//
// Sequencing: an add, or a datagram dropped on version or TTL, or a lookup in
// an empty table, goes from decide straight to done. A lookup reads every stored
// route in turn, since the route RAM has one read port and the scan reads one
// entry per cycle, then passes through a drain state before done.
// Reset: i_rst_n synchronously empties the table (the entry count goes to 0)
// and drops any pending result; entry contents are not cleared.
// Stalls: the result sits in an output register, so a new transaction is
// accepted while the previous result waits; the next result holds in the
// sequencer until the output register frees.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router_core
    import lpr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [ADDR_W-1:0] i_route_prefix_addr,
    input  logic [LEN_W-1:0]  i_route_length,
    input  logic [ADDR_W-1:0] i_route_hop_addr,
    input  logic              i_route_is_direct,
    input  logic [PORT_W-1:0] i_route_port,
    input  logic [VER_W-1:0]  i_ip_version,
    input  logic [TTL_W-1:0]  i_ttl_in,
    input  logic [ADDR_W-1:0] i_dest_addr,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_verdict,
    output logic [ADDR_W-1:0] o_hop_addr_out,
    output logic [PORT_W-1:0] o_port_out,
    output logic [TTL_W-1:0]  o_ttl_out,
    output logic [LEN_W-1:0]  o_match_length
);

    // Command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: latch the transaction, append or scan, then hand off
    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: route RAM, prefix compare, best-match and result registers
    lpr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_operation         (i_operation),
        .i_route_prefix_addr (i_route_prefix_addr),
        .i_route_length      (i_route_length),
        .i_route_hop_addr    (i_route_hop_addr),
        .i_route_is_direct   (i_route_is_direct),
        .i_route_port        (i_route_port),
        .i_ip_version        (i_ip_version),
        .i_ttl_in            (i_ttl_in),
        .i_dest_addr         (i_dest_addr),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_verdict           (o_verdict),
        .o_hop_addr_out      (o_hop_addr_out),
        .o_port_out          (o_port_out),
        .o_ttl_out           (o_ttl_out),
        .o_match_length      (o_match_length)
    );

endmodule

// File: tb/tb_ipv4_longest_prefix_router_core.sv
// ----------------------------------------------------------------------------
// tb_ipv4_longest_prefix_router_core
// Self-checking testbench for the IPv4 longest prefix router core. A shadow
// route table predicts the verdict and forwarding fields of every transaction.
// Each reply from the core is compared, field by field, with the oldest
// prediction. Directed cases come first, then random traffic with bursty
// input and a stalling output.
// ----------------------------------------------------------------------------
module tb_ipv4_longest_prefix_router_core
    import lpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
    // Settling time after the last reply before the verdict is printed, scaled
    // from the longest lookup.
    localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 4);
    // Slowest legal run: about 1000 transactions, each a full-table lookup in the
    // core, plus a sender gap and a receiver stall. Take it several times over.
    localparam int CYCLE_LIMIT   = 400_000;

    // One input transaction, both the route-add and the datagram fields
    typedef struct {
        t_op               op;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] hop;
        logic              direct;
        logic [PORT_W-1:0] port;
        logic [VER_W-1:0]  version;
        logic [TTL_W-1:0]  ttl;
        logic [ADDR_W-1:0] dest;
    } t_router_cmd;

    // One reply transaction
    typedef struct {
        t_verdict          verdict;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [TTL_W-1:0]  ttl;
        logic [LEN_W-1:0]  mlen;
    } t_router_reply;

    // Clock, reset and DUT ports. Every input starts at a known value.
    logic              i_clk               = 1'b0;
    logic              i_rst_n             = 1'b0;
    logic              i_in_valid          = 1'b0;
    logic              o_in_ready;
    logic              i_operation         = 1'b0;
    logic [ADDR_W-1:0] i_route_prefix_addr = '0;
    logic [LEN_W-1:0]  i_route_length      = '0;
    logic [ADDR_W-1:0] i_route_hop_addr    = '0;
    logic              i_route_is_direct   = 1'b0;
    logic [PORT_W-1:0] i_route_port        = '0;
    logic [VER_W-1:0]  i_ip_version        = '0;
    logic [TTL_W-1:0]  i_ttl_in            = '0;
    logic [ADDR_W-1:0] i_dest_addr         = '0;
    logic              o_out_valid;
    logic              i_out_ready         = 1'b0;
    logic [2:0]        o_verdict;
    logic [ADDR_W-1:0] o_hop_addr_out;
    logic [PORT_W-1:0] o_port_out;
    logic [TTL_W-1:0]  o_ttl_out;
    logic [LEN_W-1:0]  o_match_length;

    // Shadow route table, written in the order the core accepts adds
    logic [ADDR_W-1:0] shadow_prefix [TABLE_DEPTH];
    logic [LEN_W-1:0]  shadow_len    [TABLE_DEPTH];
    logic [ADDR_W-1:0] shadow_hop    [TABLE_DEPTH];
    logic              shadow_direct [TABLE_DEPTH];
    logic [PORT_W-1:0] shadow_port   [TABLE_DEPTH];
    int                shadow_count  = 0;

    // Predicted replies, oldest first
    t_router_reply pending_replies[$];
    t_router_reply oldest_reply;
    int            error_count    = 0;

    // Sender burst state and receiver hold-off request
    int  burst_left    = 0;
    bit  gaps_on       = 1'b1;
    int  stall_request = 0;

    ipv4_longest_prefix_router_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_route_prefix_addr(i_route_prefix_addr),
        .i_route_length     (i_route_length),
        .i_route_hop_addr   (i_route_hop_addr),
        .i_route_is_direct  (i_route_is_direct),
        .i_route_port       (i_route_port),
        .i_ip_version       (i_ip_version),
        .i_ttl_in           (i_ttl_in),
        .i_dest_addr        (i_dest_addr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_verdict          (o_verdict),
        .o_hop_addr_out     (o_hop_addr_out),
        .o_port_out         (o_port_out),
        .o_ttl_out          (o_ttl_out),
        .o_match_length     (o_match_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Network mask with the top len bits set, len in 0..32
    function automatic logic [ADDR_W-1:0] net_mask(input int len);
        if (len == 0)
            return '0;
        return ALL_ONES << (ADDR_W - len);
    endfunction

    // Apply one accepted transaction to the shadow table and return the reply
    // the core must give for it.
    function automatic t_router_reply predict_reply(input t_router_cmd c);
        t_router_reply    r;
        int               len;
        int               best;
        int               best_len;
        bit               hit;
        r.verdict = V_ADDED;
        r.hop     = '0;
        r.port    = '0;
        r.ttl     = '0;
        r.mlen    = '0;
        hit       = 1'b0;
        best      = 0;
        best_len  = 0;
        if (c.op == OP_ADD) begin
            // Saturate lengths above 32 and mask the prefix before storing
            len = (c.length > MAX_LEN) ? int'(MAX_LEN) : int'(c.length);
            if (shadow_count >= TABLE_DEPTH) begin
                r.verdict = V_FULL;
            end else begin
                shadow_prefix[shadow_count] = c.prefix & net_mask(len);
                shadow_len[shadow_count]    = len[LEN_W-1:0];
                shadow_direct[shadow_count] = c.direct;
                shadow_hop[shadow_count]    = c.direct ? '0 : c.hop;
                shadow_port[shadow_count]   = c.port;
                shadow_count++;
                r.verdict = V_ADDED;
            end
        end else if (c.version != IPV4_VERSION) begin
            r.verdict = V_BADVER;
        end else if (c.ttl < TTL_MIN) begin
            r.verdict = V_TTL;
        end else begin
            // Scan only written entries; >= lets the later entry win a tie
            for (int i = 0; i < shadow_count; i++) begin
                if ((c.dest & net_mask(shadow_len[i])) == shadow_prefix[i] &&
                    (!hit || int'(shadow_len[i]) >= best_len)) begin
                    hit      = 1'b1;
                    best     = i;
                    best_len = int'(shadow_len[i]);
                end
            end
            if (!hit) begin
                r.verdict = V_NOROUTE;
            end else begin
                r.verdict = V_FORWARD;
                r.hop     = shadow_direct[best] ? c.dest : shadow_hop[best];
                r.port    = shadow_port[best];
                r.ttl     = c.ttl - 8'd1;
                r.mlen    = best_len[LEN_W-1:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Fill the fields a transaction does not use with random bits, so the
    // core is seen to ignore them.
    function automatic t_router_cmd random_fill();
        t_router_cmd c;
        c.op      = OP_ROUTE;
        c.prefix  = $urandom();
        c.length  = LEN_W'($urandom_range(0, 63));
        c.hop     = $urandom();
        c.direct  = 1'($urandom_range(0, 1));
        c.port    = PORT_W'($urandom_range(0, 15));
        c.version = VER_W'($urandom_range(0, 15));
        c.ttl     = TTL_W'($urandom_range(0, 255));
        c.dest    = $urandom();
        return c;
    endfunction

    function automatic t_router_cmd make_add(input logic [ADDR_W-1:0] prefix,
                                             input logic [LEN_W-1:0]  length,
                                             input logic [ADDR_W-1:0] hop,
                                             input logic              direct,
                                             input logic [PORT_W-1:0] port);
        t_router_cmd c;
        c        = random_fill();
        c.op     = OP_ADD;
        c.prefix = prefix;
        c.length = length;
        c.hop    = hop;
        c.direct = direct;
        c.port   = port;
        return c;
    endfunction

    function automatic t_router_cmd make_datagram(input logic [VER_W-1:0]  version,
                                                  input logic [TTL_W-1:0]  ttl,
                                                  input logic [ADDR_W-1:0] dest);
        t_router_cmd c;
        c         = random_fill();
        c.op      = OP_ROUTE;
        c.version = version;
        c.ttl     = ttl;
        c.dest    = dest;
        return c;
    endfunction

    // Aim a destination at a stored route most of the time: inside it, or
    // just outside it by flipping its last prefix bit. Otherwise pick any.
    function automatic logic [ADDR_W-1:0] aim_dest();
        int                e;
        logic [ADDR_W-1:0] d;
        if (shadow_count == 0 || $urandom_range(0, 3) == 0)
            return $urandom();
        e = $urandom_range(0, shadow_count - 1);
        d = shadow_prefix[e] | ($urandom() & ~net_mask(shadow_len[e]));
        if (shadow_len[e] != 0 && $urandom_range(0, 3) == 0)
            d[ADDR_W - shadow_len[e]] = ~d[ADDR_W - shadow_len[e]];
        return d;
    endfunction

    // Random transaction; add_pct percent of them are route adds
    function automatic t_router_cmd random_cmd(input int add_pct);
        t_router_cmd c;
        int          e;
        c = random_fill();
        if ($urandom_range(0, 99) < add_pct) begin
            c.op     = OP_ADD;
            c.length = LEN_W'($urandom_range(1, 32));
            // Nest under an existing route half the time to build deep chains
            if (shadow_count > 0 && $urandom_range(0, 1) == 0) begin
                e        = $urandom_range(0, shadow_count - 1);
                c.prefix = shadow_prefix[e] | ($urandom() & ~net_mask(shadow_len[e]));
                c.length = LEN_W'($urandom_range(
                               (shadow_len[e] == 0) ? 1 : int'(shadow_len[e]), 32));
            end
            if ($urandom_range(0, 5) == 0)
                c.length = LEN_W'($urandom_range(33, 63));
        end else begin
            c.op      = OP_ROUTE;
            c.version = ($urandom_range(0, 6) == 0) ? VER_W'($urandom_range(0, 15))
                                                    : IPV4_VERSION;
            c.ttl     = ($urandom_range(0, 9) == 0) ? TTL_W'($urandom_range(0, 1))
                                                    : TTL_W'($urandom_range(2, 255));
            c.dest    = aim_dest();
        end
        return c;
    endfunction

    // Offer one transaction and hold it until accepted. Entered just after a
    // rising edge; returns at the edge that accepted it, valid still high.
    task automatic send_cmd(input t_router_cmd c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_operation         <= c.op;
        i_route_prefix_addr <= c.prefix;
        i_route_length      <= c.length;
        i_route_hop_addr    <= c.hop;
        i_route_is_direct   <= c.direct;
        i_route_port        <= c.port;
        i_ip_version        <= c.version;
        i_ttl_in            <= c.ttl;
        i_dest_addr         <= c.dest;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_replies.insert(pending_replies.size(), predict_reply(c));
    endtask

    // Drop valid and hold off until every predicted reply has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty table: drop checks and their order, and a lookup with no routes
    task automatic test_drop_checks();
        send_cmd(make_datagram(IPV4_VERSION, 8'd5,   32'h0102_0304)); // no route
        send_cmd(make_datagram(4'd0,         8'd0,   32'h0000_0000)); // version first
        send_cmd(make_datagram(4'd15,        8'd255, 32'hFFFF_FFFF));
        send_cmd(make_datagram(IPV4_VERSION, 8'd0,   32'h0A00_0001)); // ttl expired
        send_cmd(make_datagram(IPV4_VERSION, 8'd1,   32'h0A00_0001));
    endtask

    // Host route, unmasked and direct prefixes, saturated length, equal
    // length duplicate and a nested /16
    task automatic test_route_adds();
        send_cmd(make_add(32'hC0A8_0A37, 6'd32, 32'h0A00_0001, 1'b0, 4'd3));
        send_cmd(make_add(32'h0AFF_FFFF, 6'd8,  32'hFFFF_FFFF, 1'b1, 4'd15));
        send_cmd(make_add(32'hFFFF_FFFF, 6'd63, 32'h1111_2222, 1'b0, 4'd0));
        send_cmd(make_add(32'h0A00_0000, 6'd8,  32'h0A0A_0A0A, 1'b0, 4'd7));
        send_cmd(make_add(32'h0A01_0000, 6'd16, 32'h0A01_00FE, 1'b0, 4'd9));
        send_cmd(make_add(32'hC0A8_0A00, 6'd24, 32'h1234_5678, 1'b1, 4'd12));
    endtask

    // Longest match, direct forwarding, tie to the later entry, TTL extremes
    task automatic test_prefix_lookup();
        send_cmd(make_datagram(IPV4_VERSION, 8'd255, 32'hC0A8_0A37)); // /32 over /24
        send_cmd(make_datagram(IPV4_VERSION, 8'd64,  32'hC0A8_0A99)); // direct /24
        send_cmd(make_datagram(IPV4_VERSION, 8'd2,   32'h0A01_0203)); // /16 over /8
        send_cmd(make_datagram(IPV4_VERSION, 8'd10,  32'h0A09_0909)); // later /8
        send_cmd(make_datagram(IPV4_VERSION, 8'd128, 32'hFFFF_FFFF)); // saturated
        send_cmd(make_datagram(IPV4_VERSION, 8'd200, 32'h0000_0000)); // miss
        send_cmd(make_datagram(IPV4_VERSION, 8'd1,   32'hC0A8_0A37)); // ttl on a hit
        send_cmd(make_datagram(4'd6,         8'd0,   32'h0A01_0203));
    endtask

    // Grow the table with random routes among random lookups, one slot short
    task automatic test_random_fill();
        while (shadow_count < TABLE_DEPTH - 1)
            send_cmd(random_cmd(20));
    endtask

    // Last slot gets a default route, then adds bounce off the full table
    task automatic test_table_full();
        send_cmd(make_add($urandom(), 6'd0, $urandom(), 1'b0,
                          PORT_W'($urandom_range(0, 15))));
        repeat (3)
            send_cmd(random_cmd(100));
    endtask

    // Hold the receiver off while the sender keeps offering back to back,
    // so the core fills and stalls its input
    task automatic test_output_stall();
        gaps_on       = 1'b0;
        stall_request = 300;
        repeat (12)
            send_cmd(random_cmd(0));
        gaps_on = 1'b1;
    endtask

    // Pause the sender until every reply is back, then resume
    task automatic test_drain_pause();
        repeat (8)
            send_cmd(random_cmd(0));
        wait_drained();
        repeat (8)
            send_cmd(random_cmd(0));
    endtask

    // Bulk random traffic on the full table, stretches without sender gaps
    task automatic test_random_traffic();
        for (int n = 0; n < 900; n++) begin
            if (n % 150 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            send_cmd(random_cmd(6));
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int hold_left    = 0;
    int pattern_left = 0;
    int stall_mode   = 0;

    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            hold_left     = stall_request;
            stall_request = 0;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(10, 60);
            stall_mode   = $urandom_range(0, 3);
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Reply checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Sample at the edge; values seen here are the ones the handshake used
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none predicted, expected none, actual verdict %0d",
                         $time, o_verdict);
                error_count++;
            end else begin
                oldest_reply = pending_replies.pop_front();
                check_field("verdict",      32'(oldest_reply.verdict), 32'(o_verdict));
                check_field("hop_addr_out", oldest_reply.hop,          o_hop_addr_out);
                check_field("port_out",     32'(oldest_reply.port),    32'(o_port_out));
                check_field("ttl_out",      32'(oldest_reply.ttl),     32'(o_ttl_out));
                check_field("match_length", 32'(oldest_reply.mlen),    32'(o_match_length));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end a hung run at a generous cycle count
    // ------------------------------------------------------------------------
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release it once for the whole run
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_drop_checks();
        test_route_adds();
        test_prefix_lookup();
        test_random_fill();
        test_table_full();
        test_output_stall();
        test_drain_pause();
        test_random_traffic();

        // Drain, then give the core time to emit anything it should not
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
